/* design/mlr_pkg.sv */
package mlr_pkg;

  // Command kinds carried in the input tuser bit
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeStep = 1'b1;

  // Octant cases: major direction, then which way the minor axis moves
  localparam logic [1:0] OctRight      = 2'd0;  // x rising, shallow
  localparam logic [1:0] OctSteepRight = 2'd1;  // y major, x rising
  localparam logic [1:0] OctSteepLeft  = 2'd2;  // y major, x falling
  localparam logic [1:0] OctLeft       = 2'd3;  // x falling, shallow

  localparam int ColorBits  = 24;
  localparam int QueueDepth = 2;

  // Error term is four bits wider than a coordinate
  function automatic int err_width(input int coord_bits);
    return coord_bits + 4;
  endfunction

  // Width of one queued command: step flag, start point, colour, octant,
  // three error values and the pixel count
  function automatic int entry_width(input int coord_bits);
    return 1 + 3 * coord_bits + ColorBits + 2 + 3 * err_width(coord_bits);
  endfunction

endpackage

/* design/mlr_front.sv */
module mlr_front
  import mlr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                 mode_i,
  input  logic signed [COORD_BITS-1:0]         start_x_i,
  input  logic signed [COORD_BITS-1:0]         start_y_i,
  input  logic signed [COORD_BITS-1:0]         end_x_i,
  input  logic signed [COORD_BITS-1:0]         end_y_i,
  input  logic        [ColorBits-1:0]          line_color_i,
  output logic        [entry_width(COORD_BITS)-1:0] entry_o
);

  localparam int C = COORD_BITS;
  localparam int E = err_width(COORD_BITS);

  typedef struct packed {
    logic                step;
    logic [C-1:0]        x0;
    logic [C-1:0]        y0;
    logic [ColorBits-1:0] color;
    logic [1:0]          octant;
    logic signed [E-1:0] err0;
    logic signed [E-1:0] inc_hold;
    logic signed [E-1:0] inc_step;
    logic [C-1:0]        count;
  } entry_t;

  entry_t            ent;
  logic              swap;
  logic signed [C-1:0] ax, ay, bx, by;
  logic signed [C:0] dx, dy, ndx;
  logic signed [C:0] major, minor;
  logic signed [E-1:0] dx_e, dy_e, ndx_e, maj2, min2;
  logic [1:0]        oct;

  // Order the endpoints so the line runs toward increasing y
  assign swap = end_y_i < start_y_i;
  assign ax   = swap ? end_x_i   : start_x_i;
  assign ay   = swap ? end_y_i   : start_y_i;
  assign bx   = swap ? start_x_i : end_x_i;
  assign by   = swap ? start_y_i : end_y_i;

  assign dx  = (C+1)'(bx) - (C+1)'(ax);
  assign dy  = (C+1)'(by) - (C+1)'(ay);
  assign ndx = -dx;

  assign dx_e  = E'(dx);
  assign dy_e  = E'(dy);
  assign ndx_e = E'(ndx);

  // Pick the octant case and the spans along each axis
  always_comb begin
    if (!dx[C] && dy <= dx) begin
      oct   = OctRight;
      major = dx;
      minor = dy;
    end else if (!dx[C]) begin
      oct   = OctSteepRight;
      major = dy;
      minor = dx;
    end else if (dy > ndx) begin
      oct   = OctSteepLeft;
      major = dy;
      minor = ndx;
    end else begin
      oct   = OctLeft;
      major = ndx;
      minor = dy;
    end
  end

  assign maj2 = E'(major) <<< 1;
  assign min2 = E'(minor) <<< 1;

  // Initial error term and per-step increments
  always_comb begin
    ent          = '0;
    ent.step     = (mode_i == ModeStep);
    ent.x0       = ax;
    ent.y0       = ay;
    ent.color    = line_color_i;
    ent.octant   = oct;
    ent.count    = major[C-1:0];
    unique case (oct)
      OctRight: begin
        ent.err0     = (dy_e <<< 1) - dx_e;
        ent.inc_hold = min2;
        ent.inc_step = min2 - maj2;
      end
      OctSteepRight: begin
        ent.err0     = dy_e - (dx_e <<< 1);
        ent.inc_hold = -min2;
        ent.inc_step = maj2 - min2;
      end
      OctSteepLeft: begin
        ent.err0     = (ndx_e <<< 1) - dy_e;
        ent.inc_hold = min2;
        ent.inc_step = min2 - maj2;
      end
      default: begin
        ent.err0     = ndx_e - (dy_e <<< 1);
        ent.inc_hold = -min2;
        ent.inc_step = maj2 - min2;
      end
    endcase
  end

  assign entry_o = ent;

endmodule

/* design/mlr_queue.sv */
module mlr_queue
  import mlr_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/mlr_back.sv */
module mlr_back
  import mlr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 entry_valid_i,
  input  logic [entry_width(COORD_BITS)-1:0]   entry_i,
  output logic                                 entry_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [COORD_BITS-1:0]                pixel_x_o,
  output logic [COORD_BITS-1:0]                pixel_y_o,
  output logic [ColorBits-1:0]                 pixel_color_o,
  output logic                                 last_pixel_o
);

  localparam int C = COORD_BITS;
  localparam int E = err_width(COORD_BITS);

  typedef struct packed {
    logic                step;
    logic [C-1:0]        x0;
    logic [C-1:0]        y0;
    logic [ColorBits-1:0] color;
    logic [1:0]          octant;
    logic signed [E-1:0] err0;
    logic signed [E-1:0] inc_hold;
    logic signed [E-1:0] inc_step;
    logic [C-1:0]        count;
  } entry_t;

  entry_t              ent;
  logic [C-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [E-1:0] err_q, err_d, inc_hold_q, inc_step_q;
  logic [C-1:0]        count_q, count_d;
  logic [1:0]          oct_q;
  logic [ColorBits-1:0] color_q;
  logic                busy_q, busy_d;
  logic                out_valid_q, out_valid_d;
  logic [C-1:0]        px_q, py_q;
  logic [ColorBits-1:0] pc_q;
  logic                plast_q;
  logic                out_free, do_pixel, last, err_pos, err_neg, minor_go;

  assign ent      = entry_t'(entry_i);
  assign out_free = !out_valid_q || out_ready_i;

  // Loads and idle steps always drain; a live step waits for the output slot
  assign entry_pop_o = entry_valid_i && (!ent.step || !busy_q || out_free);
  assign do_pixel    = entry_pop_o && ent.step && busy_q;

  assign err_pos  = !err_q[E-1] && (err_q != '0);
  assign err_neg  = err_q[E-1];
  assign minor_go = (oct_q == OctRight || oct_q == OctSteepLeft) ? err_pos : err_neg;
  assign last     = (count_q == C'(1));

  // Step the line state or take a new line
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    err_d   = err_q;
    count_d = count_q;
    busy_d  = busy_q;
    if (entry_pop_o && !ent.step) begin
      cur_x_d = ent.x0;
      cur_y_d = ent.y0;
      err_d   = ent.err0;
      count_d = ent.count;
      busy_d  = (ent.count != '0);
    end else if (do_pixel) begin
      err_d   = err_q + (minor_go ? inc_step_q : inc_hold_q);
      count_d = count_q - 1'b1;
      busy_d  = !last;
      unique case (oct_q)
        OctRight: begin
          cur_x_d = cur_x_q + 1'b1;
          if (minor_go) cur_y_d = cur_y_q + 1'b1;
        end
        OctSteepRight: begin
          cur_y_d = cur_y_q + 1'b1;
          if (minor_go) cur_x_d = cur_x_q + 1'b1;
        end
        OctSteepLeft: begin
          cur_y_d = cur_y_q + 1'b1;
          if (minor_go) cur_x_d = cur_x_q - 1'b1;
        end
        default: begin
          cur_x_d = cur_x_q - 1'b1;
          if (minor_go) cur_y_d = cur_y_q + 1'b1;
        end
      endcase
    end
  end

  // Output slot: fill on a pixel, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (do_pixel) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      oct_q       <= OctRight;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      err_q       <= err_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (entry_pop_o && !ent.step) begin
        oct_q <= ent.octant;
      end
    end
  end

  // Hold line constants and the pixel payload
  always_ff @(posedge clk_i) begin
    if (entry_pop_o && !ent.step) begin
      inc_hold_q <= ent.inc_hold;
      inc_step_q <= ent.inc_step;
      color_q    <= ent.color;
    end
    if (do_pixel) begin
      px_q    <= cur_x_q;
      py_q    <= cur_y_q;
      pc_q    <= color_q;
      plast_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign last_pixel_o  = plast_q;

endmodule

/* design/midpoint_line_rasterizer.sv */
// Midpoint line rasteriser, one pixel per step request.
// Input stream: tuser = 0 is a line request carrying both endpoints and a
// colour in tdata; tuser = 1 is a step request that asks for the next pixel.
// Output stream: one request per pixel, tdata holds x, y and colour, tlast
// marks the final pixel of the line. The end point itself is never drawn.
// A step with no line in progress gives no output; a new line abandons the
// one in progress. Zero-length lines give no pixels.
// A step accepted at the input is classified and registered in the queue;
// the stepper then moves its pixel into the output register. Throughput:
// one request per cycle while the receiver keeps up, set by the stepper, which
// does one error-term add and one count compare per pixel.
// The front classifies every request into a two-entry queue; s_axis_tready
// is low only while that queue is full. When the receiver stalls, the held
// pixel waits in the output register, the queue fills and then the input
// stalls. Reset empties the queue and the output register and leaves the
// block idle with no line in progress.
module midpoint_line_rasterizer
  import mlr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color, zero pad
  input  logic [((4*COORD_BITS+ColorBits+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*COORD_BITS+ColorBits+7)/8)*8-1:0] m_axis_tdata,
  // last_pixel
  output logic m_axis_tlast
);

  localparam int C       = COORD_BITS;
  localparam int EntryW  = entry_width(COORD_BITS);
  localparam int OutUsed = 2*COORD_BITS + ColorBits;

  logic [EntryW-1:0]    push_entry, pop_entry;
  logic                 q_full, q_valid, q_pop;
  logic [C-1:0]         px, py;
  logic [ColorBits-1:0] pc;

  assign s_axis_tready = !q_full;

  mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .mode_i      (s_axis_tuser),
    .start_x_i   (s_axis_tdata[C-1:0]),
    .start_y_i   (s_axis_tdata[2*C-1:C]),
    .end_x_i     (s_axis_tdata[3*C-1:2*C]),
    .end_y_i     (s_axis_tdata[4*C-1:3*C]),
    .line_color_i(s_axis_tdata[4*C+ColorBits-1:4*C]),
    .entry_o     (push_entry)
  );

  mlr_queue #(.DATA_W(EntryW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_data_i(push_entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_entry)
  );

  mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_valid_i(q_valid),
    .entry_i      (pop_entry),
    .entry_pop_o  (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pixel_x_o    (px),
    .pixel_y_o    (py),
    .pixel_color_o(pc),
    .last_pixel_o (m_axis_tlast)
  );

  // Pack the pixel, zero-padded to whole bytes
  always_comb begin
    m_axis_tdata                     = '0;
    m_axis_tdata[C-1:0]              = px;
    m_axis_tdata[2*C-1:C]            = py;
    m_axis_tdata[OutUsed-1:2*C]      = pc;
  end

endmodule
